FILE: hdl/hee_pkg.sv
// Shared constants and helpers for the HTML entity encoder.
package hee_pkg;

    localparam int CP_W      = 21;
    localparam int CHAR_W    = 7;
    localparam int EXP_W     = 3;
    localparam int DIGIT_W   = 4;
    localparam int WEIGHT_W  = 24;
    localparam int MAX_EXP   = 6;

    typedef logic [CP_W-1:0]     cp_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [EXP_W-1:0]    exp_t;
    typedef logic [DIGIT_W-1:0]  digit_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    // Power of ten for decimal position k (0 is the units digit).
    function automatic weight_t pow10(input exp_t k);
        weight_t p;
        p = '0;
        case (k)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // d times the power of ten at position k; d is always a constant at the call site.
    function automatic weight_t digit_weight(input exp_t k, input digit_t d);
        weight_t w;
        w = WEIGHT_W'(d) * pow10(k);
        return w;
    endfunction

endpackage

FILE: hdl/hee_if.sv
// Valid/ready channel interfaces for code points in and characters out.
interface hee_in_if;
    logic         valid;
    logic         ready;
    hee_pkg::cp_t code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

interface hee_out_if;
    logic           valid;
    logic           ready;
    hee_pkg::char_t out_char;
    logic           last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

FILE: hdl/hee_digit.sv
// One decimal digit step: extracts the digit at a given position and the remainder.
module hee_digit (
    input  hee_pkg::cp_t    rem,
    input  hee_pkg::exp_t   exp_pos,
    output hee_pkg::digit_t digit,
    output hee_pkg::cp_t    rem_next
);

    hee_pkg::weight_t rem_wide;
    hee_pkg::weight_t sub;
    logic [9:1]       ge;

    assign rem_wide = hee_pkg::WEIGHT_W'(rem);

    // The remainder is always below ten times the current power, so at most
    // nine multiples fit and the count of matching compares is the digit.
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int d = 1; d <= 9; d++)
        begin
            ge[d] = rem_wide >= hee_pkg::digit_weight(exp_pos, hee_pkg::DIGIT_W'(d));
            if (ge[d])
            begin
                digit = hee_pkg::DIGIT_W'(d);
                sub   = hee_pkg::digit_weight(exp_pos, hee_pkg::DIGIT_W'(d));
            end
        end
    end

    assign rem_next = hee_pkg::CP_W'(rem_wide - sub);

endmodule

FILE: hdl/html_entity_encoder.sv
// HTML entity encoder: one code point in, its escaped ASCII form out one character at a time.
//
// cp_in carries one 21-bit code point per transaction; ch_out carries one 7-bit
// ASCII character per transaction, with last_char set on the final character of
// that code point. Code points above 127 come out as "&#", the decimal value and
// ";" (up to 10 characters). '&' always becomes "&amp;"; '"' becomes "&quot;"
// when escape_quote is set; '<' and '>' become "&lt;"/"&gt;" when escape_tags is
// set. Everything else passes through as one character. The APB port holds
// escape_quote at address 0 and escape_tags at address 4 (bit 0); write them
// only while the block is idle.
// After a code point is accepted, its first character passes through the sequencer
// register and then the output register. A code point that expands to N characters
// holds the sequencer until its last character is produced; plain characters sustain
// one code point per cycle while ch_out is ready, and the next code point is taken in
// the cycle its predecessor's last character is produced.
// Reset sets both escape controls to 1 and empties the pipeline.
// When ch_out is not ready, the output register holds its character, the
// sequencer waits and cp_in deasserts ready once the sequencer is occupied.
module html_entity_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    hee_in_if.sink             cp_in,
    hee_out_if.source          ch_out
);

    localparam logic [2:0] KIND_PLAIN = 3'd0;
    localparam logic [2:0] KIND_NUM   = 3'd1;
    localparam logic [2:0] KIND_QUOT  = 3'd2;
    localparam logic [2:0] KIND_LT    = 3'd3;
    localparam logic [2:0] KIND_GT    = 3'd4;
    localparam logic [2:0] KIND_AMP   = 3'd5;

    localparam logic [2:0] POS_AMP  = 3'd0;
    localparam logic [2:0] POS_HASH = 3'd1;
    localparam logic [2:0] POS_DIG  = 3'd2;
    localparam logic [2:0] POS_SEMI = 3'd3;

    localparam hee_pkg::char_t CH_AMP   = 7'h26;
    localparam hee_pkg::char_t CH_HASH  = 7'h23;
    localparam hee_pkg::char_t CH_SEMI  = 7'h3b;
    localparam hee_pkg::char_t CH_QUOTE = 7'h22;
    localparam hee_pkg::char_t CH_LT    = 7'h3c;
    localparam hee_pkg::char_t CH_GT    = 7'h3e;
    localparam hee_pkg::char_t CH_ZERO  = 7'h30;
    localparam hee_pkg::char_t CH_Q     = 7'h71;
    localparam hee_pkg::char_t CH_U     = 7'h75;
    localparam hee_pkg::char_t CH_O     = 7'h6f;
    localparam hee_pkg::char_t CH_T     = 7'h74;
    localparam hee_pkg::char_t CH_L     = 7'h6c;
    localparam hee_pkg::char_t CH_G     = 7'h67;
    localparam hee_pkg::char_t CH_A     = 7'h61;
    localparam hee_pkg::char_t CH_M     = 7'h6d;
    localparam hee_pkg::char_t CH_P     = 7'h70;
    localparam hee_pkg::cp_t   ASCII_MAX = 21'd127;

    localparam logic ADDR_QUOTE = 1'b0;
    localparam logic ADDR_TAGS  = 1'b1;

    logic escape_quote_reg;
    logic escape_tags_reg;
    logic cfg_write;

    logic             item_valid_reg;
    logic [2:0]       kind_reg;
    hee_pkg::cp_t     cp_reg;
    hee_pkg::exp_t    exp_reg;
    logic [2:0]       pos_reg;

    logic             out_valid_reg;
    hee_pkg::char_t   out_char_reg;
    logic             out_last_reg;

    logic             advance;
    logic             take;
    hee_pkg::char_t   char_now;
    logic             last_now;
    logic [2:0]       kind_next;
    hee_pkg::exp_t    exp_next;
    hee_pkg::digit_t  digit;
    hee_pkg::cp_t     rem_next;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_quote_reg <= 1'b1;
            escape_tags_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_QUOTE)
                escape_quote_reg <= pwdata[0];
            else
                escape_tags_reg <= pwdata[0];
        end
    end

    assign prdata = {31'd0, (paddr[2] == ADDR_TAGS) ? escape_tags_reg : escape_quote_reg};

    // Classify the incoming code point and find the position of its leading decimal digit.
    always_comb
    begin
        if (cp_in.code_point > ASCII_MAX)
            kind_next = KIND_NUM;
        else if (cp_in.code_point[6:0] == CH_QUOTE && escape_quote_reg)
            kind_next = KIND_QUOT;
        else if (cp_in.code_point[6:0] == CH_LT && escape_tags_reg)
            kind_next = KIND_LT;
        else if (cp_in.code_point[6:0] == CH_GT && escape_tags_reg)
            kind_next = KIND_GT;
        else if (cp_in.code_point[6:0] == CH_AMP)
            kind_next = KIND_AMP;
        else
            kind_next = KIND_PLAIN;

        exp_next = '0;
        for (int k = 1; k <= hee_pkg::MAX_EXP; k++)
        begin
            if (hee_pkg::WEIGHT_W'(cp_in.code_point) >= hee_pkg::pow10(hee_pkg::EXP_W'(k)))
                exp_next = exp_next + 3'd1;
        end
    end

    hee_digit u_digit (
        .rem      (cp_reg),
        .exp_pos  (exp_reg),
        .digit    (digit),
        .rem_next (rem_next)
    );

    // Character produced by the sequencer in its current step.
    always_comb
    begin
        char_now = cp_reg[6:0];
        last_now = 1'b0;
        unique case (kind_reg) inside
            KIND_PLAIN:
            begin
                char_now = cp_reg[6:0];
                last_now = 1'b1;
            end
            KIND_NUM:
            begin
                case (pos_reg)
                    POS_AMP:  char_now = CH_AMP;
                    POS_HASH: char_now = CH_HASH;
                    POS_DIG:  char_now = CH_ZERO + hee_pkg::CHAR_W'(digit);
                    default:  char_now = CH_SEMI;
                endcase
                last_now = (pos_reg == POS_SEMI);
            end
            KIND_QUOT:
            begin
                case (pos_reg)
                    3'd0:    char_now = CH_AMP;
                    3'd1:    char_now = CH_Q;
                    3'd2:    char_now = CH_U;
                    3'd3:    char_now = CH_O;
                    3'd4:    char_now = CH_T;
                    default: char_now = CH_SEMI;
                endcase
                last_now = (pos_reg == 3'd5);
            end
            KIND_LT, KIND_GT:
            begin
                case (pos_reg)
                    3'd0:    char_now = CH_AMP;
                    3'd1:    char_now = (kind_reg == KIND_LT) ? CH_L : CH_G;
                    3'd2:    char_now = CH_T;
                    default: char_now = CH_SEMI;
                endcase
                last_now = (pos_reg == 3'd3);
            end
            KIND_AMP:
            begin
                case (pos_reg)
                    3'd0:    char_now = CH_AMP;
                    3'd1:    char_now = CH_A;
                    3'd2:    char_now = CH_M;
                    3'd3:    char_now = CH_P;
                    default: char_now = CH_SEMI;
                endcase
                last_now = (pos_reg == 3'd4);
            end
            default:
            begin
                char_now = cp_reg[6:0];
                last_now = 1'b1;
            end
        endcase
    end

    assign advance     = item_valid_reg && (!out_valid_reg || ch_out.ready);
    assign cp_in.ready = !item_valid_reg || (advance && last_now);
    assign take        = cp_in.valid && cp_in.ready;

    // Sequencer: holds the code point being expanded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (take)
            item_valid_reg <= 1'b1;
        else if (advance && last_now)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind_next;
            cp_reg   <= cp_in.code_point;
            exp_reg  <= exp_next;
            pos_reg  <= '0;
        end
        else if (advance && !last_now)
        begin
            if (kind_reg == KIND_NUM && pos_reg == POS_DIG)
            begin
                cp_reg <= rem_next;
                if (exp_reg == '0)
                    pos_reg <= POS_SEMI;
                else
                    exp_reg <= exp_reg - 3'd1;
            end
            else
            begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (ch_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg <= char_now;
            out_last_reg <= last_now;
        end
    end

    assign ch_out.valid     = out_valid_reg;
    assign ch_out.out_char  = out_char_reg;
    assign ch_out.last_char = out_last_reg;

endmodule
